@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hpa_pkg.sv @@
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types, constants and helpers of the generational handle pool.
// ----------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

   // pool geometry
   localparam int SLOTS  = 12;
   localparam int SLOT_W = $clog2(SLOTS + 1);   // slot number or end-of-chain
   localparam int ADDR_W = $clog2(SLOTS);       // memory index
   localparam int STEP_W = $clog2(SLOTS);       // walk step counter

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [STEP_W-1:0] step_type;

   localparam slot_type NIL_SLOT  = slot_type'(SLOTS);
   localparam slot_type LAST_SLOT = slot_type'(SLOTS - 1);
   localparam step_type STEP_LAST = step_type'(SLOTS - 1);

   // generation counts down and wraps to this value instead of reaching zero
   localparam logic [15:0] GEN_WRAP = 16'hFFF1;

   // request kinds
   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_OLDEST = 2'd2;
   localparam logic [1:0] KIND_RESET  = 2'd3;

   // link of an entry that was not written since the pool was rebuilt
   function automatic slot_type reset_link(addr_type a);
      slot_type s;
      s = slot_type'(a);
      return (a == '0) ? NIL_SLOT : s - slot_type'(1);
   endfunction

endpackage

`default_nettype wire

@@ rtl/handle_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// handle_pool_allocator
// Generational handle pool: free and active lists chained through one link
// memory, stored handles in a second memory, one word per request.
// ----------------------------------------------------------------------------
// Reset pool and a bad slot index are answered straight from idle; allocate
// from the free list first reads its head; freeing or recycling may walk the
// active list one slot per cycle through the single read port of the link
// memory. One request at a time: busy covers it.
// Reset (synchronous) empties the active list, chains every slot on the free
// list and clears the generation; results cannot be stalled by the receiver.
`default_nettype none

module handle_pool_allocator
   import hpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_handle,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_handle,
   output logic             rsp_status,
   output logic             rsp_recycled
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC_ISS,
      ST_ALLOC_RD,
      ST_OLD_WALK,
      ST_OLD_FIX,
      ST_PUSH,
      ST_FREE_CHK,
      ST_FREE_WALK,
      ST_FREE_FIX
   } state_type;

   // control and list state
   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] hnd_ff, hnd_in;
   slot_type    idx_ff, idx_in;
   slot_type    idx_link_ff, idx_link_in;
   slot_type    cur_ff, cur_in;
   slot_type    prev_ff, prev_in;
   step_type    step_ff, step_in;
   logic        last_ff, last_in;
   logic        recyc_ff, recyc_in;
   slot_type    active_head_ff, active_head_in;
   slot_type    free_head_ff, free_head_in;
   logic [15:0] gen_ff, gen_in;

   // result word
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_handle_ff, rsp_handle_in;
   logic        rsp_status_ff, rsp_status_in;
   logic        rsp_rec_ff, rsp_rec_in;

   // memory access
   logic        rd_en;
   slot_type    rd_slot;
   logic        lk_we;
   slot_type    lk_wslot;
   slot_type    lk_wd;
   logic        hd_we;
   slot_type    hd_wslot;
   logic [31:0] hd_wd;
   logic        vld_clr;

   slot_type    link_mem [SLOTS];
   logic [31:0] hnd_mem  [SLOTS];
   logic [SLOTS-1:0] lnk_vld_ff;
   logic [SLOTS-1:0] hnd_vld_ff;
   slot_type    lnk_q_ff;
   logic [31:0] hnd_q_ff;
   logic        lvld_q_ff;
   logic        hvld_q_ff;
   addr_type    rd_addr_q_ff;

   slot_type    lk_rd;
   logic [31:0] h_rd;
   logic [15:0] gen_dec;
   logic [15:0] gen_nx;
   logic [31:0] new_handle;

   // unwritten entries read as the rebuilt pool
   assign lk_rd = lvld_q_ff ? lnk_q_ff : reset_link(rd_addr_q_ff);
   assign h_rd  = hvld_q_ff ? hnd_q_ff : 32'd0;

   // next generation and the handle it forms with the free head
   assign gen_dec    = gen_ff - 16'd1;
   assign gen_nx     = (gen_dec == 16'd0) ? GEN_WRAP : gen_dec;
   assign new_handle = {gen_nx, 16'(free_head_ff)};

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_recycled      = rsp_rec_ff;

   // sequence one request through the memories
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      hnd_in         = hnd_ff;
      idx_in         = idx_ff;
      idx_link_in    = idx_link_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      step_in        = step_ff;
      last_in        = last_ff;
      recyc_in       = recyc_ff;
      active_head_in = active_head_ff;
      free_head_in   = free_head_ff;
      gen_in         = gen_ff;
      rsp_valid_in   = 1'b0;
      rsp_handle_in  = rsp_handle_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_rec_in     = rsp_rec_ff;
      rd_en          = 1'b0;
      rd_slot        = active_head_ff;
      lk_we          = 1'b0;
      lk_wslot       = cur_ff;
      lk_wd          = NIL_SLOT;
      hd_we          = 1'b0;
      hd_wslot       = idx_ff;
      hd_wd          = 32'd0;
      vld_clr        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_kind;
               hnd_in   = req_handle;
               recyc_in = 1'b0;
               case (req_kind)
                  KIND_ALLOC, KIND_OLDEST: begin
                     if (req_kind == KIND_ALLOC && free_head_ff < NIL_SLOT) begin
                        rd_en    = 1'b1;
                        rd_slot  = free_head_ff;
                        state_in = ST_ALLOC_RD;
                     end else if (active_head_ff < NIL_SLOT) begin
                        // walk to the active tail
                        prev_in  = NIL_SLOT;
                        cur_in   = active_head_ff;
                        step_in  = '0;
                        rd_en    = 1'b1;
                        rd_slot  = active_head_ff;
                        state_in = ST_OLD_WALK;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_handle_in = 32'd0;
                        rsp_status_in = 1'b1;
                        rsp_rec_in    = 1'b0;
                     end
                  end
                  KIND_FREE: begin
                     if (req_handle[15:0] >= 16'(SLOTS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_handle_in = 32'd0;
                        rsp_status_in = 1'b1;
                        rsp_rec_in    = 1'b0;
                     end else begin
                        idx_in   = req_handle[SLOT_W-1:0];
                        rd_en    = 1'b1;
                        rd_slot  = req_handle[SLOT_W-1:0];
                        state_in = ST_FREE_CHK;
                     end
                  end
                  default: begin
                     // rebuild the pool; generation is kept
                     vld_clr        = 1'b1;
                     free_head_in   = LAST_SLOT;
                     active_head_in = NIL_SLOT;
                     rsp_valid_in   = 1'b1;
                     rsp_handle_in  = 32'd0;
                     rsp_status_in  = 1'b0;
                     rsp_rec_in     = 1'b0;
                  end
               endcase
            end
         end

         ST_ALLOC_ISS: begin
            rd_en    = 1'b1;
            rd_slot  = free_head_ff;
            state_in = ST_ALLOC_RD;
         end

         ST_ALLOC_RD: begin
            // pop free head, push it at the active head
            free_head_in   = lk_rd;
            gen_in         = gen_nx;
            hd_we          = 1'b1;
            hd_wslot       = free_head_ff;
            hd_wd          = new_handle;
            lk_we          = 1'b1;
            lk_wslot       = free_head_ff;
            lk_wd          = active_head_ff;
            active_head_in = free_head_ff;
            rsp_valid_in   = 1'b1;
            rsp_handle_in  = new_handle;
            rsp_status_in  = 1'b0;
            rsp_rec_in     = recyc_ff;
            state_in       = ST_IDLE;
         end

         ST_OLD_WALK: begin
            if (lk_rd >= NIL_SLOT) begin
               state_in = ST_OLD_FIX;
            end else begin
               prev_in = cur_ff;
               cur_in  = lk_rd;
               if (step_ff == STEP_LAST) begin
                  state_in = ST_OLD_FIX;
               end else begin
                  step_in = step_ff + step_type'(1);
                  rd_en   = 1'b1;
                  rd_slot = lk_rd;
               end
            end
         end

         ST_OLD_FIX: begin
            // unhook the tail from its predecessor
            if (prev_ff >= NIL_SLOT) begin
               active_head_in = NIL_SLOT;
            end else begin
               lk_we    = 1'b1;
               lk_wslot = prev_ff;
               lk_wd    = NIL_SLOT;
            end
            idx_in   = cur_ff;
            state_in = ST_PUSH;
         end

         ST_PUSH: begin
            // return the slot to the free list
            hd_we        = 1'b1;
            hd_wslot     = idx_ff;
            hd_wd        = 32'd0;
            lk_we        = 1'b1;
            lk_wslot     = idx_ff;
            lk_wd        = free_head_ff;
            free_head_in = idx_ff;
            if (op_ff == KIND_ALLOC) begin
               recyc_in = 1'b1;
               state_in = ST_ALLOC_ISS;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = 32'd0;
               rsp_status_in = 1'b0;
               rsp_rec_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_FREE_CHK: begin
            idx_link_in = lk_rd;
            if (h_rd != hnd_ff || (active_head_ff != idx_ff && active_head_ff >= NIL_SLOT))
            begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = 32'd0;
               rsp_status_in = 1'b1;
               rsp_rec_in    = 1'b0;
               state_in      = ST_IDLE;
            end else if (active_head_ff == idx_ff) begin
               active_head_in = lk_rd;
               state_in       = ST_PUSH;
            end else begin
               // search for the predecessor
               cur_in   = active_head_ff;
               step_in  = '0;
               last_in  = 1'b0;
               rd_en    = 1'b1;
               rd_slot  = active_head_ff;
               state_in = ST_FREE_WALK;
            end
         end

         ST_FREE_WALK: begin
            if (lk_rd == idx_ff) begin
               state_in = ST_FREE_FIX;
            end else if (last_ff || lk_rd >= NIL_SLOT) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = 32'd0;
               rsp_status_in = 1'b1;
               rsp_rec_in    = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               cur_in  = lk_rd;
               rd_en   = 1'b1;
               rd_slot = lk_rd;
               if (step_ff == STEP_LAST) begin
                  last_in = 1'b1;
               end else begin
                  step_in = step_ff + step_type'(1);
               end
            end
         end

         ST_FREE_FIX: begin
            // bypass the freed slot
            lk_we    = 1'b1;
            lk_wslot = cur_ff;
            lk_wd    = idx_link_ff;
            state_in = ST_PUSH;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_head_ff <= NIL_SLOT;
         free_head_ff   <= LAST_SLOT;
         gen_ff         <= 16'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_head_ff <= active_head_in;
         free_head_ff   <= free_head_in;
         gen_ff         <= gen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff         <= op_in;
      hnd_ff        <= hnd_in;
      idx_ff        <= idx_in;
      idx_link_ff   <= idx_link_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      step_ff       <= step_in;
      last_ff       <= last_in;
      recyc_ff      <= recyc_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   // link and handle memories, registered read
   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_wslot[ADDR_W-1:0]] <= lk_wd;
      end
      if (hd_we) begin
         hnd_mem[hd_wslot[ADDR_W-1:0]] <= hd_wd;
      end
      if (rd_en) begin
         lnk_q_ff     <= link_mem[rd_slot[ADDR_W-1:0]];
         hnd_q_ff     <= hnd_mem[rd_slot[ADDR_W-1:0]];
         rd_addr_q_ff <= rd_slot[ADDR_W-1:0];
      end
   end

   // track written entries; clear on reset and pool rebuild
   always_ff @(posedge clock) begin
      if (reset) begin
         lnk_vld_ff <= '0;
         hnd_vld_ff <= '0;
         lvld_q_ff  <= 1'b0;
         hvld_q_ff  <= 1'b0;
      end else begin
         if (vld_clr) begin
            lnk_vld_ff <= '0;
            hnd_vld_ff <= '0;
         end else begin
            if (lk_we) begin
               lnk_vld_ff[lk_wslot[ADDR_W-1:0]] <= 1'b1;
            end
            if (hd_we) begin
               hnd_vld_ff[hd_wslot[ADDR_W-1:0]] <= 1'b1;
            end
         end
         if (rd_en) begin
            lvld_q_ff <= lnk_vld_ff[rd_slot[ADDR_W-1:0]];
            hvld_q_ff <= hnd_vld_ff[rd_slot[ADDR_W-1:0]];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/hpa_checker.sv @@
// ----------------------------------------------------------------------------
// hpa_checker
// Port-level checks of the handle pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hpa_checker
   import hpa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_kind,
   input wire logic [31:0] req_handle,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_result_handle,
   input wire logic        rsp_status,
   input wire logic        rsp_recycled
);

   // pool rebuild answers in the next cycle with success
   `HPA_ASSERT_NXT(a_reset_next, clock, reset,
      start && !busy && req_kind == KIND_RESET,
      rsp_valid && !rsp_status, "pool rebuild not answered next cycle")

   // a word is delivered only once the request is finished
   `HPA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "result word while busy")

   // a rejected request carries no handle
   `HPA_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid && rsp_status,
      rsp_result_handle == 32'd0 && !rsp_recycled, "rejected word with handle")

   // a new handle names a real slot and a nonzero generation
   `HPA_ASSERT_IMP(a_handle_ok, clock, reset, rsp_valid && rsp_result_handle != 32'd0,
      rsp_result_handle[15:0] < 16'(SLOTS) && rsp_result_handle[31:16] != 16'd0,
      "bad handle")

   // a free with an out-of-range slot index is rejected in the next cycle
   `HPA_ASSERT_NXT(a_bad_index, clock, reset,
      start && !busy && req_kind == KIND_FREE && req_handle[15:0] >= 16'(SLOTS),
      rsp_valid && rsp_status, "bad slot index not rejected next cycle")

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (.*);

`default_nettype wire
